// ===== src/rpi_pkg.sv =====
// Shared widths, types and register codes for the ray/parallelogram intersect core.
package rpi_pkg;

    localparam int COMPONENT_BITS = 21;
    localparam int FRACTION_BITS  = 10;
    localparam int FIELD_W        = 63;

    localparam int EDGE_W  = COMPONENT_BITS + 1;
    localparam int CROSS_W = 2 * EDGE_W + 1;
    localparam int SPLIT_W = CROSS_W / 2;
    localparam int HIGH_W  = CROSS_W - SPLIT_W;
    localparam int PROD_W  = EDGE_W + CROSS_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int MAG_W   = DOT_W;

    localparam int EPS_W          = 20;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(10737);
    localparam int EPS_UNIT_BITS  = 30;
    localparam int CMP_W          = DOT_W + EPS_UNIT_BITS + EPS_W + 3 * FRACTION_BITS;

    localparam int UV_BITS  = 17;
    localparam int DIST_W   = 32;
    localparam int FRAC_OUT = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = EPS_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CULL_MODE   = 1'b0,
        CFG_DET_EPSILON = 1'b1
    } cfg_index_t;

    typedef logic signed [EDGE_W-1:0] edge_t;

    typedef struct packed {
        logic             cull_mode;
        logic [EPS_W-1:0] det_epsilon;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic             tneg;
        logic [MAG_W-1:0] det;
        logic [MAG_W-1:0] un;
        logic [MAG_W-1:0] vn;
        logic [MAG_W-1:0] tmag;
    } job_t;

    function automatic edge_t comp(input logic [FIELD_W-1:0] w, input int k);
        return edge_t'($signed(w[k*COMPONENT_BITS +: COMPONENT_BITS]));
    endfunction

endpackage

// ===== src/rpi_req_if.sv =====
// Input item channel: ray and parallelogram corners.
interface rpi_req_if
    import rpi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] ray_origin;
    logic [FIELD_W-1:0] ray_direction;
    logic [FIELD_W-1:0] corner_base;
    logic [FIELD_W-1:0] corner_first;
    logic [FIELD_W-1:0] corner_second;

    modport source (output valid, ray_origin, ray_direction, corner_base, corner_first,
                    corner_second, input ready);
    modport sink (input valid, ray_origin, ray_direction, corner_base, corner_first,
                  corner_second, output ready);
endinterface

// ===== src/rpi_rsp_if.sv =====
// Result item channel: hit flag, distance and edge coordinates.
interface rpi_rsp_if
    import rpi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DIST_W-1:0] ray_distance;
    logic [UV_BITS-1:0]       coord_first;
    logic [UV_BITS-1:0]       coord_second;

    modport source (output valid, hit, ray_distance, coord_first, coord_second, input ready);
    modport sink (input valid, hit, ray_distance, coord_first, coord_second, output ready);
endinterface

// ===== src/rpi_cfg_if.sv =====
// Configuration write channel.
interface rpi_cfg_if
    import rpi_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ray_parallelogram_intersect_core.sv =====
// Top level of the ray/parallelogram intersect core: config registers, front, queue, back.
//
//  channel | dir | handshake    | carries
//  --------+-----+--------------+--------------------------------------------------
//  cfg     | in  | valid/ready  | index, data (cull_mode, det_epsilon)
//  req     | in  | valid/ready  | ray_origin, ray_direction, corner_base/first/second
//  rsp     | out | valid/ready  | hit, ray_distance, coord_first, coord_second
//
//  One item per cycle unless rsp stalls; 8 front stages, the queue, 32 divide stages
//  and the result register. The t divider, one quotient bit per stage, sets the depth.
//  Reset clears valid bits, queue pointers and config (two-sided test, epsilon 10737).
//  A stalled rsp holds the back; the front keeps taking items until the 4-entry queue fills.
module ray_parallelogram_intersect_core
    import rpi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rpi_cfg_if.sink   cfg,
    rpi_req_if.sink   req,
    rpi_rsp_if.source rsp
);

    cfg_t cfg_reg;
    logic push, pop, q_full, q_empty;
    job_t push_job, pop_job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cull_mode   <= 1'b0;
            cfg_reg.det_epsilon <= EPS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_CULL_MODE:   cfg_reg.cull_mode   <= cfg.data[0];
                CFG_DET_EPSILON: cfg_reg.det_epsilon <= cfg.data;
                default:         ;
            endcase
        end
    end

    rpi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    rpi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    rpi_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (pop_job),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

// ===== src/rpi_front.sv =====
// Front pipeline: edges, cross products, dot products, determinant tests and classification.
module rpi_front
    import rpi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rpi_req_if.sink    req,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    typedef logic signed [2*EDGE_W-1:0]        prod2_t;
    typedef logic signed [CROSS_W-1:0]         cross_t;
    typedef logic signed [EDGE_W+SPLIT_W:0]    lo_t;
    typedef logic signed [EDGE_W+HIGH_W-1:0]   hi_t;
    typedef logic signed [PROD_W-1:0]          prod_t;
    typedef logic signed [DOT_W-1:0]           dot_t;
    typedef logic signed [DOT_W:0]             nw_t;

    logic       en;
    logic [8:1] vld_reg;

    edge_t  d_s1_reg  [3], e1_s1_reg [3], e2_s1_reg [3], tv_s1_reg [3];
    edge_t  a_s2_reg  [4][3];
    prod2_t pa_s2_reg [3], pb_s2_reg [3], qa_s2_reg [3], qb_s2_reg [3];
    edge_t  a_s3_reg  [4][3];
    cross_t p_s3_reg  [3], q_s3_reg [3];
    lo_t    lo_s4_reg [4][3];
    hi_t    hi_s4_reg [4][3];
    prod_t  pr_s5_reg [4][3];
    dot_t   dt_s6_reg [4];
    nw_t    nm_s7_reg [4];
    logic   miss_s7_reg;
    job_t   job_s8_reg;

    job_t job_s8_next;
    nw_t  tabs;
    logic eps_miss;
    logic un_bad;
    logic vn_bad;

    assign en        = !vld_reg[8] || !q_full;
    assign req.ready = en;
    assign push      = vld_reg[8] && en;
    assign push_job  = job_s8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:1], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_s1_reg[k]  <= comp(req.ray_direction, k);
                e1_s1_reg[k] <= comp(req.corner_first, k) - comp(req.corner_base, k);
                e2_s1_reg[k] <= comp(req.corner_second, k) - comp(req.corner_base, k);
                tv_s1_reg[k] <= comp(req.ray_origin, k) - comp(req.corner_base, k);
            end
            for (int k = 0; k < 3; k++)
            begin
                a_s2_reg[0][k] <= e1_s1_reg[k];
                a_s2_reg[1][k] <= tv_s1_reg[k];
                a_s2_reg[2][k] <= d_s1_reg[k];
                a_s2_reg[3][k] <= e2_s1_reg[k];
                pa_s2_reg[k] <= d_s1_reg[(k+1)%3] * e2_s1_reg[(k+2)%3];
                pb_s2_reg[k] <= d_s1_reg[(k+2)%3] * e2_s1_reg[(k+1)%3];
                qa_s2_reg[k] <= tv_s1_reg[(k+1)%3] * e1_s1_reg[(k+2)%3];
                qb_s2_reg[k] <= tv_s1_reg[(k+2)%3] * e1_s1_reg[(k+1)%3];
            end
            a_s3_reg <= a_s2_reg;
            for (int k = 0; k < 3; k++)
            begin
                p_s3_reg[k] <= cross_t'(pa_s2_reg[k]) - cross_t'(pb_s2_reg[k]);
                q_s3_reg[k] <= cross_t'(qa_s2_reg[k]) - cross_t'(qb_s2_reg[k]);
            end
            for (int j = 0; j < 4; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lo_s4_reg[j][k] <= a_s3_reg[j][k]
                        * $signed({1'b0, (j < 2) ? p_s3_reg[k][SPLIT_W-1:0]
                                                 : q_s3_reg[k][SPLIT_W-1:0]});
                    hi_s4_reg[j][k] <= a_s3_reg[j][k]
                        * $signed((j < 2) ? p_s3_reg[k][CROSS_W-1:SPLIT_W]
                                          : q_s3_reg[k][CROSS_W-1:SPLIT_W]);
                end
            end
            for (int j = 0; j < 4; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pr_s5_reg[j][k] <= (prod_t'(hi_s4_reg[j][k]) <<< SPLIT_W)
                                       + prod_t'(lo_s4_reg[j][k]);
                end
                dt_s6_reg[j] <= dot_t'(pr_s5_reg[j][0]) + dot_t'(pr_s5_reg[j][1])
                                + dot_t'(pr_s5_reg[j][2]);
            end
            for (int j = 0; j < 4; j++)
            begin
                nm_s7_reg[j] <= dt_s6_reg[0][DOT_W-1] ? -nw_t'(dt_s6_reg[j])
                                                      : nw_t'(dt_s6_reg[j]);
            end
            miss_s7_reg <= (dt_s6_reg[0] == '0) || (dt_s6_reg[0][DOT_W-1] && cfg.cull_mode);
            job_s8_reg  <= job_s8_next;
        end
    end

    // det, u, v, t numerators in nm_s7_reg[0..3], already sign-normalized
    always_comb
    begin
        eps_miss = ((CMP_W'(nm_s7_reg[0][MAG_W-1:0]) << EPS_UNIT_BITS)
                    < (CMP_W'(cfg.det_epsilon) << (3 * FRACTION_BITS)));
        un_bad   = nm_s7_reg[1][DOT_W] || (nm_s7_reg[1] > nm_s7_reg[0]);
        vn_bad   = nm_s7_reg[2][DOT_W] || (nm_s7_reg[2] > nm_s7_reg[0]);
        tabs     = nm_s7_reg[3][DOT_W] ? -nm_s7_reg[3] : nm_s7_reg[3];
        job_s8_next.hit  = !(miss_s7_reg || eps_miss || un_bad || vn_bad);
        job_s8_next.tneg = nm_s7_reg[3][DOT_W];
        job_s8_next.det  = nm_s7_reg[0][MAG_W-1:0];
        job_s8_next.un   = nm_s7_reg[1][MAG_W-1:0];
        job_s8_next.vn   = nm_s7_reg[2][MAG_W-1:0];
        job_s8_next.tmag = tabs[MAG_W-1:0];
    end

endmodule

// ===== src/rpi_queue.sv =====
// Short queue between the classify front and the divide back.
module rpi_queue
    import rpi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ===== src/rpi_back.sv =====
// Back pipeline: bit-per-stage dividers for u, v and t, saturation and result register.
module rpi_back
    import rpi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_job,
    output logic       pop,
    rpi_rsp_if.source  rsp
);

    localparam int RW    = MAG_W + 1;
    localparam int STEPS = DIST_W;

    typedef struct packed {
        logic               hit;
        logic               tneg;
        logic               ovf;
        logic [MAG_W-1:0]   det;
        logic [RW-1:0]      ru;
        logic [RW-1:0]      rv;
        logic [RW-1:0]      rt;
        logic [UV_BITS-1:0] qu;
        logic [UV_BITS-1:0] qv;
        logic [DIST_W-1:0]  tlo;
        logic [DIST_W-1:0]  qt;
    } bst_t;

    localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    function automatic bst_t step(input bst_t a, input logic uv_on);
        bst_t          r;
        logic [RW-1:0] d;
        logic [RW-1:0] x;
        r = a;
        d = RW'(a.det);
        if (uv_on)
        begin
            r.qu = {a.qu[UV_BITS-2:0], (a.ru >= d)};
            r.ru = ((a.ru >= d) ? a.ru - d : a.ru) << 1;
            r.qv = {a.qv[UV_BITS-2:0], (a.rv >= d)};
            r.rv = ((a.rv >= d) ? a.rv - d : a.rv) << 1;
        end
        x     = {a.rt[MAG_W-1:0], a.tlo[DIST_W-1]};
        r.tlo = a.tlo << 1;
        r.qt  = {a.qt[DIST_W-2:0], (x >= d)};
        r.rt  = (x >= d) ? x - d : x;
        return r;
    endfunction

    logic               adv;
    logic [STEPS-1:0]   vld_reg;
    bst_t               stg_reg [STEPS];
    bst_t               cur     [STEPS];
    bst_t               nxt     [STEPS];
    bst_t               fin;
    logic [DIST_W-1:0]  dist_sat;

    assign adv = !rsp.valid || rsp.ready;
    assign pop = adv && !q_empty;

    always_comb
    begin
        cur[0].hit  = q_job.hit;
        cur[0].tneg = q_job.tneg;
        cur[0].ovf  = (q_job.tmag >> FRAC_OUT) >= q_job.det;
        cur[0].det  = q_job.det;
        cur[0].ru   = RW'(q_job.un);
        cur[0].rv   = RW'(q_job.vn);
        cur[0].rt   = RW'(q_job.tmag >> FRAC_OUT);
        cur[0].qu   = '0;
        cur[0].qv   = '0;
        cur[0].tlo  = DIST_W'(q_job.tmag[FRAC_OUT-1:0]) << (DIST_W - FRAC_OUT);
        cur[0].qt   = '0;
        for (int s = 1; s < STEPS; s++)
        begin
            cur[s] = stg_reg[s-1];
        end
        for (int s = 0; s < STEPS; s++)
        begin
            nxt[s] = step(cur[s], (s < UV_BITS));
        end
    end

    always_comb
    begin
        fin = stg_reg[STEPS-1];
        if (fin.tneg)
        begin
            dist_sat = (fin.ovf || (fin.qt[DIST_W-1] && (fin.qt[DIST_W-2:0] != '0)))
                       ? DIST_MIN : -fin.qt;
        end
        else
        begin
            dist_sat = (fin.ovf || fin.qt[DIST_W-1]) ? DIST_MAX : fin.qt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rsp.valid <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg   <= {vld_reg[STEPS-2:0], !q_empty};
            rsp.valid <= vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                stg_reg[s] <= nxt[s];
            end
            rsp.hit          <= fin.hit;
            rsp.ray_distance <= fin.hit ? $signed(dist_sat) : '0;
            rsp.coord_first  <= fin.hit ? fin.qu : '0;
            rsp.coord_second <= fin.hit ? fin.qv : '0;
        end
    end

endmodule
